// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/rpdc_pkg.sv
// ----------------------------------------------------------------------------
// rpdc_pkg
// Types, register codes and calendar helpers for the drift correction unit.
// ----------------------------------------------------------------------------
package rpdc_pkg;

  localparam int unsigned SecW  = 6;
  localparam int unsigned MinW  = 6;
  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 7;
  localparam int unsigned DoyW  = 9;
  localparam int unsigned AmtW  = 7;
  localparam int unsigned IntW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  localparam logic [AmtW-1:0] ShiftLimit = 7'd120;
  localparam logic [MonW-1:0] LastMonth  = 4'd12;
  localparam logic [MonW-1:0] February   = 4'd2;
  localparam logic [MinW-1:0] MinFirst   = 6'd3;
  localparam logic [MinW-1:0] MinLast    = 6'd57;

  typedef enum logic [CfgIdxW-1:0] {
    CfgShiftSeconds = 2'd0,
    CfgIntervalDays = 2'd1,
    CfgShiftForward = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OpCheck   = 1'b0,
    OpRestart = 1'b1
  } op_e;

  typedef struct packed {
    logic [AmtW-1:0] shift_seconds;
    logic [IntW-1:0] interval_days;
    logic            shift_forward;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } item_t;

  typedef struct packed {
    logic            corrected;
    logic [MinW-1:0] minute;
    logic [SecW-1:0] second;
  } result_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [DoyW-1:0]  doy;
  } ref_t;

  // days before the first of month m (month 0 adds nothing)
  function automatic logic [DoyW-1:0] month_start(logic [MonW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DoyW-1:0] day_of_year(logic [DayW-1:0]  day,
                                                  logic [MonW-1:0]  month,
                                                  logic [YearW-1:0] year);
    logic [MonW-1:0] m;
    logic            leap_add;
    m        = (month > LastMonth) ? LastMonth : month;
    leap_add = (year[1:0] == 2'b00) && (m > February);
    return {{(DoyW-DayW){1'b0}}, day} + month_start(m) + {{(DoyW-1){1'b0}}, leap_add};
  endfunction

endpackage

// File: sv/rtc_periodic_drift_correction_unit.sv
// ----------------------------------------------------------------------------
// rtc_periodic_drift_correction_unit
// Periodic seconds correction for a real-time clock.
//
// Input stream carries one calendar time per beat (tdata) and the operation
// (tuser: 0 check, 1 restart the reference at this date). Output stream gives
// one beat per input: shifted second and minute in tdata, tuser high when the
// time was adjusted and must be written back to the clock.
// Pipeline: input register, then result register. Throughput: one beat per
// cycle while the receiver keeps up; the reference date is updated as an
// item leaves the input register, so the next item already sees it.
// The cfg port writes shift amount, interval and direction; write it only
// while no beats are in flight.
// Reset clears the configuration, the reference date and both valid flags.
// A stalled receiver holds the result register; one more beat is taken into
// the input register, then s_axis_tready_o drops until the output drains.
// ----------------------------------------------------------------------------
module rtc_periodic_drift_correction_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rpdc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rpdc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // second[5:0], minute[11:6], day[16:12], month[20:17], year[27:21], zero
  input  logic [rpdc_pkg::InDataW-1:0]    s_axis_tdata_i,
  // operation[0]
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // second_out[5:0], minute_out[11:6], zero
  output logic [rpdc_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // corrected[0]
  output logic                            m_axis_tuser_o
);

  rpdc_pkg::cfg_t    cfg_q;
  rpdc_pkg::ref_t    ref_q;
  rpdc_pkg::item_t   item_q;
  logic              in_vld_q;
  rpdc_pkg::result_t res_q;
  logic              out_vld_q;

  rpdc_pkg::result_t res_d;
  logic              ref_upd;
  rpdc_pkg::ref_t    ref_new;
  logic              advance;
  logic              take;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rpdc_pkg::cfg_idx_e'(cfg_idx_i))
        rpdc_pkg::CfgShiftSeconds:
          cfg_q.shift_seconds <= cfg_wdata_i[rpdc_pkg::AmtW-1:0];
        rpdc_pkg::CfgIntervalDays:
          cfg_q.interval_days <= cfg_wdata_i[rpdc_pkg::IntW-1:0];
        rpdc_pkg::CfgShiftForward:
          cfg_q.shift_forward <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.op     <= rpdc_pkg::op_e'(s_axis_tuser_i);
      item_q.second <= s_axis_tdata_i[5:0];
      item_q.minute <= s_axis_tdata_i[11:6];
      item_q.day    <= s_axis_tdata_i[16:12];
      item_q.month  <= s_axis_tdata_i[20:17];
      item_q.year   <= s_axis_tdata_i[27:21];
    end
  end

  rpdc_calc u_calc (
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .ref_i     (ref_q),
    .res_o     (res_d),
    .ref_upd_o (ref_upd),
    .ref_new_o (ref_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (advance && ref_upd) begin
      ref_q <= ref_new;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_q.corrected;
  assign m_axis_tdata_o  = {4'b0000, res_q.minute, res_q.second};

endmodule

// File: sv/rpdc_calc.sv
// ----------------------------------------------------------------------------
// rpdc_calc
// Decides whether one item triggers a correction and computes the shifted
// second and minute plus the new reference date.
// ----------------------------------------------------------------------------
module rpdc_calc (
  input  rpdc_pkg::item_t   item_i,
  input  rpdc_pkg::cfg_t    cfg_i,
  input  rpdc_pkg::ref_t    ref_i,
  output rpdc_pkg::result_t res_o,
  output logic              ref_upd_o,
  output rpdc_pkg::ref_t    ref_new_o
);

  logic [rpdc_pkg::DoyW-1:0] doy;
  logic [rpdc_pkg::AmtW-1:0] amount;
  logic                      enable;
  logic [rpdc_pkg::DoyW:0]   due;       // ref day + interval
  logic [rpdc_pkg::DoyW:0]   reach_new; // year length + day, across a year change
  logic                      same_ok;
  logic                      diff_ok;
  logic                      fire;
  logic [7:0]                t;
  logic [2:0]                q;
  logic [7:0]                q60;
  logic [7:0]                rem;
  logic [rpdc_pkg::MinW:0]   min_sum;

  assign doy    = rpdc_pkg::day_of_year(item_i.day, item_i.month, item_i.year);
  assign amount = (cfg_i.shift_seconds > rpdc_pkg::ShiftLimit) ?
                  rpdc_pkg::ShiftLimit : cfg_i.shift_seconds;

  assign enable = (item_i.op == rpdc_pkg::OpCheck) && (amount != '0) &&
                  (cfg_i.interval_days != '0) &&
                  (item_i.minute >= rpdc_pkg::MinFirst) &&
                  (item_i.minute <= rpdc_pkg::MinLast);

  assign due       = {1'b0, ref_i.doy} + {2'b00, cfg_i.interval_days};
  assign same_ok   = {1'b0, doy} >= due;
  assign reach_new = ((ref_i.year[1:0] == 2'b00) ? 10'd366 : 10'd365) + {1'b0, doy};
  assign diff_ok   = reach_new >= due;
  assign fire      = enable && ((item_i.year == ref_i.year) ? same_ok : diff_ok);

  // Work on seconds only; a backward shift borrows three minutes up front.
  // Minute is at least 3 when firing, so the total never goes negative.
  assign t = {2'b00, item_i.second} +
             (cfg_i.shift_forward ? {1'b0, amount} : (8'd180 - {1'b0, amount}));

  always_comb begin
    if (t >= 8'd240) begin
      q = 3'd4;
    end else if (t >= 8'd180) begin
      q = 3'd3;
    end else if (t >= 8'd120) begin
      q = 3'd2;
    end else if (t >= 8'd60) begin
      q = 3'd1;
    end else begin
      q = 3'd0;
    end
  end

  always_comb begin
    case (q)
      3'd1:    q60 = 8'd60;
      3'd2:    q60 = 8'd120;
      3'd3:    q60 = 8'd180;
      3'd4:    q60 = 8'd240;
      default: q60 = 8'd0;
    endcase
  end

  assign rem     = t - q60;
  assign min_sum = {1'b0, item_i.minute} + {4'b0000, q} -
                   (cfg_i.shift_forward ? 7'd0 : 7'd3);

  always_comb begin
    res_o.corrected = fire;
    res_o.second    = fire ? rem[rpdc_pkg::SecW-1:0] : item_i.second;
    res_o.minute    = fire ? min_sum[rpdc_pkg::MinW-1:0] : item_i.minute;
  end

  assign ref_upd_o      = (item_i.op == rpdc_pkg::OpRestart) || fire;
  assign ref_new_o.year = item_i.year;
  assign ref_new_o.doy  = doy;

endmodule

// File: sv/rpdc_checker.sv
// ----------------------------------------------------------------------------
// rpdc_checker
// Port-level checks for the drift correction unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpdc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [rpdc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tuser_o
);

  logic                          out_stall;
  logic                          fix_beat;
  logic [rpdc_pkg::OutDataW:0]   out_beat;
  logic [rpdc_pkg::SecW-1:0]     sec_out;
  logic [rpdc_pkg::MinW-1:0]     min_out;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign fix_beat  = m_axis_tvalid_o && m_axis_tuser_o;
  assign out_beat  = {m_axis_tuser_o, m_axis_tdata_o};
  assign sec_out   = m_axis_tdata_o[5:0];
  assign min_out   = m_axis_tdata_o[11:6];

  // stalled output beat holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_beat))

  // input side only backs up when the output is stalled
  `ASSERT_IMPL(a_ready_stall, clk_i, rst_ni, !s_axis_tready_o, out_stall)

  // a shifted second is always a proper second of minute
  `ASSERT_IMPL(a_sec_range, clk_i, rst_ni, fix_beat, sec_out < 6'd60)

  // shift never pushes the minute above 60 nor below one
  `ASSERT_IMPL(a_min_range, clk_i, rst_ni, fix_beat, (min_out <= 6'd60) && (min_out != 6'd0))

endmodule

bind rtc_periodic_drift_correction_unit rpdc_checker u_rpdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the RTC periodic drift correction unit. Calendar
// beats go in through the slave stream, and a shadow model of the reference
// date and of the registers predicts each output beat. The run has a few
// directed dates, then random phases with different register settings.
// Sender bursts and gaps, receiver stall patterns and one long receiver
// hold-off put back-pressure on the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 200;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [rpdc_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [rpdc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [rpdc_pkg::InDataW-1:0]  s_axis_tdata_i = '0;
  logic                          s_axis_tuser_i = 1'b0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [rpdc_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic                          m_axis_tuser_o;

  rtc_periodic_drift_correction_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow registers and reference date
  logic [rpdc_pkg::AmtW-1:0]  cfg_amt = '0;
  logic [rpdc_pkg::IntW-1:0]  cfg_int = '0;
  logic                       cfg_fwd = 1'b0;
  logic [rpdc_pkg::YearW-1:0] ref_yr = '0;
  logic [rpdc_pkg::DoyW-1:0]  ref_doy = '0;

  int cum_days [0:12] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  rpdc_pkg::item_t   date_q [$];
  rpdc_pkg::result_t adjusted_time_q [$];
  rpdc_pkg::item_t   cur_item;
  int      mismatches = 0;
  int      beats_in = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      cycle_cnt = 0;

  function automatic rpdc_pkg::result_t predict_adjusted_time(rpdc_pkg::item_t it);
    int      m;
    int      doy;
    int      amount;
    int      elapsed;
    int      total;
    int      yr_len;
    bit      fire;
    rpdc_pkg::result_t r;
    m      = (it.month > 4'd12) ? 12 : int'(it.month);
    doy    = int'(it.day) + cum_days[m] + ((it.year[1:0] == 2'b00 && m > 2) ? 1 : 0);
    amount = (cfg_amt > 7'd120) ? 120 : int'(cfg_amt);
    r.corrected = 1'b0;
    r.second    = it.second;
    r.minute    = it.minute;
    fire        = 1'b0;
    if (it.op == rpdc_pkg::OpRestart) begin
      ref_yr  = it.year;
      ref_doy = rpdc_pkg::DoyW'(doy);
      return r;
    end
    if (amount == 0 || cfg_int == 0 || it.minute < 6'd3 || it.minute > 6'd57) return r;
    if (it.year == ref_yr) begin
      fire = (doy >= int'(ref_doy)) && (doy - int'(ref_doy) >= int'(cfg_int));
    end else begin
      // days left in the reference year plus day of year now
      yr_len  = (ref_yr[1:0] == 2'b00) ? 366 : 365;
      elapsed = yr_len - int'(ref_doy) + doy;
      fire    = elapsed >= int'(cfg_int);
    end
    if (!fire) return r;
    total = int'(it.minute) * 60 + int'(it.second);
    if (cfg_fwd) begin
      total += amount;
    end else if (total < amount) begin
      return r;
    end else begin
      total -= amount;
    end
    r.corrected = 1'b1;
    r.second    = rpdc_pkg::SecW'(total % 60);
    r.minute    = rpdc_pkg::MinW'(total / 60);
    ref_yr      = it.year;
    ref_doy     = rpdc_pkg::DoyW'(doy);
    return r;
  endfunction

  function automatic rpdc_pkg::item_t random_date(int base_year);
    rpdc_pkg::item_t it;
    if ($urandom_range(0, 9) == 0) begin
      // noise: every field over its full width
      it.op     = rpdc_pkg::op_e'($urandom_range(0, 1));
      it.second = rpdc_pkg::SecW'($urandom);
      it.minute = rpdc_pkg::MinW'($urandom);
      it.day    = rpdc_pkg::DayW'($urandom);
      it.month  = rpdc_pkg::MonW'($urandom);
      it.year   = rpdc_pkg::YearW'($urandom);
    end else begin
      it.op     = ($urandom_range(0, 7) == 0) ? rpdc_pkg::OpRestart : rpdc_pkg::OpCheck;
      it.second = rpdc_pkg::SecW'($urandom_range(0, 59));
      it.minute = rpdc_pkg::MinW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 59)
                                                               : $urandom_range(3, 57));
      it.day    = rpdc_pkg::DayW'($urandom_range(1, 31));
      it.month  = rpdc_pkg::MonW'($urandom_range(1, 12));
      it.year   = rpdc_pkg::YearW'((base_year + $urandom_range(0, 1)) % 100);
    end
    return it;
  endfunction

  task automatic push_date(rpdc_pkg::op_e op, int sec, int mi, int d, int mo, int y);
    rpdc_pkg::item_t it;
    it.op     = op;
    it.second = rpdc_pkg::SecW'(sec);
    it.minute = rpdc_pkg::MinW'(mi);
    it.day    = rpdc_pkg::DayW'(d);
    it.month  = rpdc_pkg::MonW'(mo);
    it.year   = rpdc_pkg::YearW'(y);
    date_q.push_back(it);
  endtask

  task automatic write_reg(rpdc_pkg::cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= rpdc_pkg::CfgDataW'(val);
    case (idx)
      rpdc_pkg::CfgShiftSeconds: cfg_amt = rpdc_pkg::AmtW'(val);
      rpdc_pkg::CfgIntervalDays: cfg_int = rpdc_pkg::IntW'(val);
      default:                   cfg_fwd = 1'(val);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(int amt, int days, int fwd);
    write_reg(rpdc_pkg::CfgShiftSeconds, amt);
    write_reg(rpdc_pkg::CfgIntervalDays, days);
    write_reg(rpdc_pkg::CfgShiftForward, fwd);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (date_q.size() != 0 || s_axis_tvalid_i || adjusted_time_q.size() != 0)
      @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // sender: bursts of beats with gaps, valid held until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        adjusted_time_q.push_back(predict_adjusted_time(cur_item));
        beats_in++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (date_q.size() != 0) begin
          cur_item = date_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {4'b0, cur_item.year, cur_item.month, cur_item.day,
                              cur_item.minute, cur_item.second};
          s_axis_tuser_i  <= cur_item.op;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern drawn at random from four modes, one long hold-off
  int rx_cycle = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!hold_done && beats_in >= 500) begin
      hold_done = 1'b1;
      hold_left = 400;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
        2:       m_axis_tready_i <= (rx_cycle % 4 == 0);
        default: m_axis_tready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // output checker
  always @(posedge clk_i) begin
    rpdc_pkg::result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (adjusted_time_q.size() == 0) begin
        $display("%0t: output beat expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        mismatches++;
      end else begin
        exp_r = adjusted_time_q.pop_front();
        if (m_axis_tuser_o !== exp_r.corrected) begin
          $display("%0t: corrected expected %0d actual %0d",
                   $time, exp_r.corrected, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tdata_o[5:0] !== exp_r.second) begin
          $display("%0t: second_out expected %0d actual %0d",
                   $time, exp_r.second, m_axis_tdata_o[5:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[11:6] !== exp_r.minute) begin
          $display("%0t: minute_out expected %0d actual %0d",
                   $time, exp_r.minute, m_axis_tdata_o[11:6]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    int amt;
    int days;
    int base_year;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // registers at reset: everything disabled
    @(negedge clk_i);
    push_date(rpdc_pkg::OpRestart, 0, 10, 1, 1, 24);
    push_date(rpdc_pkg::OpCheck, 30, 30, 20, 6, 25);
    wait_idle();

    set_regs(10, 1, 1);
    @(negedge clk_i);
    push_date(rpdc_pkg::OpRestart, 0, 10, 1, 1, 24);
    push_date(rpdc_pkg::OpCheck, 0, 10, 1, 1, 24);    // same day, too early
    push_date(rpdc_pkg::OpCheck, 55, 10, 2, 1, 24);   // one day later, fires
    push_date(rpdc_pkg::OpCheck, 0, 2, 4, 1, 24);     // minute too low
    push_date(rpdc_pkg::OpCheck, 0, 58, 4, 1, 24);    // minute too high
    push_date(rpdc_pkg::OpCheck, 0, 3, 4, 1, 24);
    push_date(rpdc_pkg::OpCheck, 59, 57, 5, 1, 24);   // carries into minute 58
    push_date(rpdc_pkg::OpCheck, 0, 20, 1, 1, 24);    // day before reference
    push_date(rpdc_pkg::OpCheck, 0, 20, 31, 12, 23);  // smaller year
    push_date(rpdc_pkg::OpRestart, 0, 0, 0, 0, 1);    // month zero, day zero
    push_date(rpdc_pkg::OpCheck, 63, 30, 31, 15, 1);  // month above range, second 63
    push_date(rpdc_pkg::OpCheck, 63, 57, 0, 0, 127);  // top of year width
    push_date(rpdc_pkg::OpRestart, 0, 0, 31, 12, 0);  // leap year end
    wait_idle();

    set_regs(127, 1, 0);                              // amount above the limit, backward
    @(negedge clk_i);
    push_date(rpdc_pkg::OpCheck, 0, 3, 1, 1, 1);
    push_date(rpdc_pkg::OpCheck, 59, 57, 3, 3, 1);
    push_date(rpdc_pkg::OpCheck, 0, 3, 3, 3, 1);      // same day, too early
    push_date(rpdc_pkg::OpCheck, 45, 40, 29, 2, 4);
    wait_idle();

    set_regs(120, 255, 1);
    @(negedge clk_i);
    push_date(rpdc_pkg::OpRestart, 0, 30, 1, 1, 50);
    push_date(rpdc_pkg::OpCheck, 0, 30, 12, 9, 50);   // 254 days
    push_date(rpdc_pkg::OpCheck, 0, 30, 13, 9, 50);   // 255 days
    push_date(rpdc_pkg::OpCheck, 59, 57, 31, 12, 51);
    wait_idle();

    // random phases with varied settings
    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 5))
        0:       amt = 0;
        1:       amt = 1;
        2:       amt = 120;
        3:       amt = 127;
        default: amt = $urandom_range(1, 127);
      endcase
      case ($urandom_range(0, 5))
        0:       days = 0;
        1:       days = 1;
        2:       days = 255;
        default: days = $urandom_range(1, 40);
      endcase
      if (ph == 0) begin
        amt  = 60;
        days = 3;
      end
      set_regs(amt, days, $urandom_range(0, 1));
      base_year = $urandom_range(0, 99);
      @(negedge clk_i);
      for (int i = 0; i < PhaseItems; i++) date_q.push_back(random_date(base_year));
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    mismatches += adjusted_time_q.size();
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
